>>> src/irf_pkg.sv
// Shared types and constants for the index range filter and run merger.
`timescale 1ns / 1ps

package irf_pkg;

    localparam int TIME_W  = 64;
    localparam int ID_W    = 32;
    localparam int POS_W   = 32;
    localparam int LEN_W   = 32;
    localparam int TDATA_W = 2 * TIME_W + 2 * ID_W + POS_W + LEN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Result queue: one record can produce two results.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_FROM    = 3'd0,
        CFG_TIME_TO      = 3'd1,
        CFG_ID_FILTER_ON = 3'd2,
        CFG_ID_LOW       = 3'd3,
        CFG_ID_HIGH      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_from;
        logic [TIME_W-1:0] time_to;
        logic              id_filter_on;
        logic [ID_W-1:0]   id_low;
        logic [ID_W-1:0]   id_high;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] min_time;
        logic [TIME_W-1:0] max_time;
        logic [ID_W-1:0]   min_id;
        logic [ID_W-1:0]   max_id;
        logic [POS_W-1:0]  position;
        logic [LEN_W-1:0]  length;
    } rec_t;

    typedef struct packed {
        rec_t run;
        logic done;
        logic empty;
    } res_t;

    // Pushes from the run tracker into the result queue.
    typedef struct packed {
        logic push_a;
        logic push_b;
        res_t res_a;
        res_t res_b;
    } push_t;

endpackage

>>> src/index_range_filter_merge.sv
// Top level: index record window filter with contiguous run merging.
// A record is taken into the input register, evaluated there against the
// windows and the held run, and its results are written to the result queue.
// Throughput: one record per cycle while the result queue has room for two
// results, since a record can yield two.
// Reset (aresetn low, synchronous) restores the configuration defaults,
// drops any held run and empties the input register and result queue.
`timescale 1ns / 1ps

module index_range_filter_merge (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [irf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irf_pkg::CFG_DATA_W-1:0]   cfg_data,

    // Record input. tdata, low to high: rec_min_time, rec_max_time,
    // rec_min_id, rec_max_id, rec_position, rec_length.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [irf_pkg::TDATA_W-1:0]      s_tdata,
    input  logic                             s_tlast,     // end_of_index

    // Result output. tdata, low to high: run_min_time, run_max_time,
    // run_min_id, run_max_id, run_position, run_length.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [irf_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tlast,     // scan_done
    output logic                             m_tuser      // scan_empty
);

    // Configuration registers. Writes must arrive only while the block is idle;
    // the block does not enforce this, and the channel is always ready.
    irf_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.time_from    <= '0;
            cfg_reg.time_to      <= '1;
            cfg_reg.id_filter_on <= 1'b0;
            cfg_reg.id_low       <= '0;
            cfg_reg.id_high      <= '1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                irf_pkg::CFG_TIME_FROM: begin
                    cfg_reg.time_from <= cfg_data[irf_pkg::TIME_W-1:0];
                end
                irf_pkg::CFG_TIME_TO: begin
                    cfg_reg.time_to <= cfg_data[irf_pkg::TIME_W-1:0];
                end
                irf_pkg::CFG_ID_FILTER_ON: begin
                    cfg_reg.id_filter_on <= cfg_data[0];
                end
                irf_pkg::CFG_ID_LOW: begin
                    cfg_reg.id_low <= cfg_data[irf_pkg::ID_W-1:0];
                end
                irf_pkg::CFG_ID_HIGH: begin
                    cfg_reg.id_high <= cfg_data[irf_pkg::ID_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register. A taken record is held here and evaluated from it;
    // evaluation waits only when the result queue lacks room for two.
    logic                              in_valid_reg;
    logic                              in_last_reg;
    irf_pkg::rec_t                     in_rec_reg;
    irf_pkg::rec_t                     s_rec;
    logic                              step;
    logic                              hit;
    irf_pkg::push_t                    push;
    irf_pkg::res_t                     head;
    logic [irf_pkg::OUTQ_CNT_W-1:0]    q_count;
    logic                              pop;

    assign s_rec.min_time = s_tdata[63:0];
    assign s_rec.max_time = s_tdata[127:64];
    assign s_rec.min_id   = s_tdata[159:128];
    assign s_rec.max_id   = s_tdata[191:160];
    assign s_rec.position = s_tdata[223:192];
    assign s_rec.length   = s_tdata[255:224];

    assign step     = in_valid_reg &&
                      (q_count <= irf_pkg::OUTQ_CNT_W'(irf_pkg::OUTQ_DEPTH - 2));
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_rec_reg  <= s_rec;
            in_last_reg <= s_tlast;
        end
    end

    irf_match u_match (
        .cfg (cfg_reg),
        .rec (in_rec_reg),
        .hit (hit)
    );

    irf_run u_run (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .hit     (hit),
        .last    (in_last_reg),
        .rec     (in_rec_reg),
        .push    (push)
    );

    irf_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .count   (q_count)
    );

    // The queue head drives the result channel directly.
    assign m_tvalid = (q_count != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {head.run.length, head.run.position, head.run.max_id,
                       head.run.min_id, head.run.max_time, head.run.min_time};
    assign m_tlast  = head.done;
    assign m_tuser  = head.empty;

    // A second result in one cycle only ever follows a first one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.push_b |-> push.push_a)
        else $error("second result pushed without a first");

    // The final record of a scan always produces a result marked done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && in_last_reg) |-> (push.push_a &&
                                   (push.push_b ? push.res_b.done : push.res_a.done)))
        else $error("end of scan produced no done result");

    // An empty-scan result is always the last of its scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("empty result not marked as scan end");

    // The queue never holds more than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= irf_pkg::OUTQ_CNT_W'(irf_pkg::OUTQ_DEPTH))
        else $error("result queue overflow");

endmodule

>>> src/irf_match.sv
// Window test of one index record against the time and id windows.
`timescale 1ns / 1ps

module irf_match (
    input  irf_pkg::cfg_t cfg,
    input  irf_pkg::rec_t rec,
    output logic          hit
);

    logic time_ok;
    logic id_ok;

    // Only the two endpoints of each span are tested.
    assign time_ok = ((cfg.time_from <= rec.min_time) && (rec.min_time <= cfg.time_to)) ||
                     ((cfg.time_from <= rec.max_time) && (rec.max_time <= cfg.time_to));

    assign id_ok = !cfg.id_filter_on ||
                   ((cfg.id_low <= rec.min_id) && (rec.min_id <= cfg.id_high)) ||
                   ((cfg.id_low <= rec.max_id) && (rec.max_id <= cfg.id_high));

    assign hit = time_ok && id_ok;

endmodule

>>> src/irf_run.sv
// Held run register with merge, emit and end-of-scan flush.
`timescale 1ns / 1ps

module irf_run (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic            hit,
    input  logic            last,
    input  irf_pkg::rec_t   rec,
    output irf_pkg::push_t  push
);

    logic          run_held_reg;
    logic          run_held_next;
    irf_pkg::rec_t held_reg;
    irf_pkg::rec_t held_next;

    logic [irf_pkg::POS_W:0] held_end;
    logic [irf_pkg::LEN_W:0] len_sum;
    logic                    adjacent;
    logic                    merge;
    logic                    emit_old;
    logic                    held_pre;
    irf_pkg::rec_t           run_pre;
    irf_pkg::res_t           old_res;
    irf_pkg::res_t           final_res;

    // The end is formed in 33 bits, so a run past the top never merges.
    assign held_end = {1'b0, held_reg.position} + {1'b0, held_reg.length};
    assign adjacent = (held_end == {1'b0, rec.position});
    assign len_sum  = {1'b0, held_reg.length} + {1'b0, rec.length};
    assign merge    = hit && run_held_reg && adjacent;
    assign emit_old = hit && run_held_reg && !adjacent;

    always_comb begin
        run_pre  = held_reg;
        held_pre = run_held_reg || hit;
        if (merge) begin
            run_pre.length = len_sum[irf_pkg::LEN_W] ? {irf_pkg::LEN_W{1'b1}}
                                                     : len_sum[irf_pkg::LEN_W-1:0];
        end else if (hit) begin
            run_pre = rec;
        end
    end

    always_comb begin
        old_res.run   = held_reg;
        old_res.done  = 1'b0;
        old_res.empty = 1'b0;
        if (held_pre) begin
            final_res.run   = run_pre;
            final_res.empty = 1'b0;
        end else begin
            final_res.run   = '0;
            final_res.empty = 1'b1;
        end
        final_res.done = 1'b1;
    end

    // The displaced run always goes first; the flush result follows it.
    assign push.push_a = step && (emit_old || last);
    assign push.push_b = step && emit_old && last;
    assign push.res_a  = emit_old ? old_res : final_res;
    assign push.res_b  = final_res;

    assign run_held_next = last ? 1'b0 : held_pre;
    assign held_next     = run_pre;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_held_reg <= 1'b0;
        end else if (step) begin
            run_held_reg <= run_held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            held_reg <= held_next;
        end
    end

endmodule

>>> src/irf_outq.sv
// Small result queue taking up to two results per cycle, giving one.
`timescale 1ns / 1ps

module irf_outq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  irf_pkg::push_t                    push,
    input  logic                              pop,
    output irf_pkg::res_t                     head,
    output logic [irf_pkg::OUTQ_CNT_W-1:0]    count
);

    irf_pkg::res_t                   mem [irf_pkg::OUTQ_DEPTH];
    logic [irf_pkg::OUTQ_PTR_W-1:0]  wr_ptr_reg;
    logic [irf_pkg::OUTQ_PTR_W-1:0]  wr_ptr_next;
    logic [irf_pkg::OUTQ_PTR_W-1:0]  wr_ptr_plus1;
    logic [irf_pkg::OUTQ_PTR_W-1:0]  rd_ptr_reg;
    logic [irf_pkg::OUTQ_PTR_W-1:0]  rd_ptr_next;
    logic [irf_pkg::OUTQ_CNT_W-1:0]  count_reg;
    logic [irf_pkg::OUTQ_CNT_W-1:0]  count_next;
    logic [irf_pkg::OUTQ_CNT_W-1:0]  n_push;

    assign wr_ptr_plus1 = wr_ptr_reg + irf_pkg::OUTQ_PTR_W'(1);
    assign n_push = irf_pkg::OUTQ_CNT_W'(push.push_a) + irf_pkg::OUTQ_CNT_W'(push.push_b);
    assign wr_ptr_next = wr_ptr_reg + n_push[irf_pkg::OUTQ_PTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + irf_pkg::OUTQ_PTR_W'(pop);
    assign count_next  = count_reg + n_push - irf_pkg::OUTQ_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push_a) begin
            mem[wr_ptr_reg] <= push.res_a;
        end
        if (push.push_b) begin
            mem[wr_ptr_plus1] <= push.res_b;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule
